// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on the rising edge and disabled
// while the synchronous active-low reset is applied. Empty under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LFSS_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("assertion failed");
`define LFSS_ASSERT_NEVER(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define LFSS_ASSERT(lbl, ck, rn, prop)
`define LFSS_ASSERT_NEVER(lbl, ck, rn, prop)
`endif
`endif

// ===== src/lfss_pkg.sv =====
// ---------------------------------------------------------------------------
// lfss_pkg
// Widths, constants, codes and small helper functions for the line-follower
// steering and speed block.
// ---------------------------------------------------------------------------
`default_nettype none

package lfss_pkg;

  localparam int PAT_W     = 8;
  localparam int TACH_W    = 8;
  localparam int STEER_W   = 9;
  localparam int SPEED_W   = 7;
  localparam int LAPS_W    = 8;
  localparam int ROT_W     = 16;
  localparam int CORNER_W  = 16;
  localparam int BASE_W    = 7;
  localparam int SLOW_W    = 6;
  localparam int MARGIN_W  = 16;
  localparam int BOOST_W   = 8;
  localparam int LIMIT_W   = 10;
  localparam int ONES_W    = 4;
  localparam int POS_W     = 3;
  localparam int K_W       = 4;
  localparam int MUL_A_W   = 16;
  localparam int MUL_B_W   = 10;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SAT_IN_W  = 17;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0]  UNITY_Q8     = 10'd256;
  localparam logic [MUL_B_W-1:0]  ONE_Q9       = 10'd512;
  localparam logic [SPEED_W-1:0]  SPEED_MAX    = 7'd100;
  localparam logic [CORNER_W-1:0] END_MARK     = 16'hffff;
  localparam logic [STEER_W-1:0]  STEER_CENTRE = 9'd375;

  typedef enum logic {
    OP_SENSE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_BASE_SPEED    = 3'd0,
    REG_CORNER_SLOW   = 3'd1,
    REG_CORNER_MARGIN = 3'd2,
    REG_BOOST_PER_ROT = 3'd3,
    REG_BOOST_LIMIT   = 3'd4
  } cfg_reg_t;

  // Servo compare value for each sensor bit, far left first.
  function automatic logic [STEER_W-1:0] servo_cmp(input logic [POS_W-1:0] pos);
    logic [STEER_W-1:0] v;
    case (pos)
      3'd0:    v = 9'd287;
      3'd1:    v = 9'd316;
      3'd2:    v = 9'd345;
      3'd3:    v = 9'd365;
      3'd4:    v = 9'd384;
      3'd5:    v = 9'd404;
      3'd6:    v = 9'd433;
      3'd7:    v = 9'd462;
      default: v = STEER_CENTRE;
    endcase
    return v;
  endfunction

  // Slowdown multiple of c for outer bits; zero marks the two centre bits.
  function automatic logic [K_W-1:0] corner_k(input logic [POS_W-1:0] pos);
    logic [K_W-1:0] k;
    case (pos)
      3'd0, 3'd7: k = 4'd10;
      3'd1, 3'd6: k = 4'd9;
      3'd2, 3'd5: k = 4'd8;
      default:    k = 4'd0;
    endcase
    return k;
  endfunction

  function automatic logic [ONES_W-1:0] count_ones(input logic [PAT_W-1:0] p);
    logic [ONES_W-1:0] c;
    c = '0;
    for (int i = 0; i < PAT_W; i++) begin
      c = c + ONES_W'(p[i]);
    end
    return c;
  endfunction

  function automatic logic [POS_W-1:0] bit_pos(input logic [PAT_W-1:0] p);
    logic [POS_W-1:0] q;
    q = '0;
    for (int i = 0; i < PAT_W; i++) begin
      if (p[i]) begin
        q = POS_W'(i);
      end
    end
    return q;
  endfunction

  function automatic logic [SPEED_W-1:0] sat_speed(input logic [SAT_IN_W-1:0] v);
    logic [SPEED_W-1:0] s;
    if (v > SAT_IN_W'(SPEED_MAX)) begin
      s = SPEED_MAX;
    end else begin
      s = v[SPEED_W-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/lfss_ifs.sv =====
// ---------------------------------------------------------------------------
// lfss channel interfaces
// Valid/ready channels for sensor and tick items and for result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface lfss_in_if;
  import lfss_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [PAT_W-1:0]  line_pattern;
  logic [TACH_W-1:0] tach_pulses;

  modport source (output valid, output op, output line_pattern, output tach_pulses,
                  input ready);
  modport sink   (input valid, input op, input line_pattern, input tach_pulses,
                  output ready);
endinterface

interface lfss_out_if;
  import lfss_pkg::*;
  logic               valid;
  logic               ready;
  logic               steer_valid;
  logic [STEER_W-1:0] steering_compare;
  logic               speed_valid;
  logic [SPEED_W-1:0] speed_command;
  logic [LAPS_W-1:0]  lap_count;

  modport source (output valid, output steer_valid, output steering_compare,
                  output speed_valid, output speed_command, output lap_count,
                  input ready);
  modport sink   (input valid, input steer_valid, input steering_compare,
                  input speed_valid, input speed_command, input lap_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/lfss_corner_store.sv =====
// ---------------------------------------------------------------------------
// lfss_corner_store
// Corner distance memory: one write port, one registered read port. Entries
// never written since reset read as zero through per-entry valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module lfss_corner_store #(
  parameter int SLOTS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]           wr_addr,
  input  wire logic [lfss_pkg::CORNER_W-1:0]      wr_data,
  input  wire logic [$clog2(SLOTS)-1:0]           rd_addr,
  output logic      [lfss_pkg::CORNER_W-1:0]      rd_value
);
  import lfss_pkg::*;

  logic [CORNER_W-1:0] mem_r [SLOTS];
  logic [SLOTS-1:0]    valid_r;
  logic [CORNER_W-1:0] rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_value = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== src/line_follower_steer_speed_core.sv =====
// Paths: a tick or a multi-bit/zero pattern goes from decode to the output
// register; an outer single bit runs the cut multiply and corner speed step
// (no saturation step when the cut reaches one); a centre bit runs the speed
// multiply, after the corner scan once two laps have been counted (one store
// entry per cycle). Flow: one item at a time; ready returns when the result
// is registered.
// Reset: synchronous, active low; the corner store is cleared through valid
// bits at once, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// line_follower_steer_speed_core
// Steering and speed sequencer for a line-following car. A small state
// machine drives one shared multiplier and a compare/subtract path through
// a sequence of states for each item.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module line_follower_steer_speed_core #(
  parameter int CORNER_SLOTS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lfss_in_if.sink                                in_ch,
  lfss_out_if.source                             out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lfss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [lfss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [lfss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);
  import lfss_pkg::*;

  // Width of a store address, and of the corner index which may also hold
  // the store depth itself once the store is full.
  localparam int IW = $clog2(CORNER_SLOTS);
  localparam int CW = $clog2(CORNER_SLOTS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(CORNER_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CUT,
    S_CSPD,
    S_CSAT,
    S_SCAN_RD,
    S_SCAN,
    S_MARG,
    S_BMUL,
    S_BCAP,
    S_SPD,
    S_SSAT,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [BASE_W-1:0]   base_r;
  logic [SLOW_W-1:0]   slow_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [BOOST_W-1:0]  bpr_r;
  logic [LIMIT_W-1:0]  limit_r;

  // The item being worked on.
  op_t               op_r;
  logic [PAT_W-1:0]  pat_r;
  logic [TACH_W-1:0] tach_r;

  // Architectural state.
  logic [PAT_W-1:0]  prev_r;
  logic [CW-1:0]     idx_r;
  logic              cflag_r;
  logic              lflag_r;
  logic [LAPS_W-1:0] laps_r;
  logic [ROT_W-1:0]  rot_r;
  logic [2:0]        phase_r;

  // Working registers of the sequencer.
  logic [IW-1:0]      chk_r;
  logic [MARGIN_W-1:0] excess_r;
  logic [LIMIT_W-1:0] m_r;
  logic [PROD_W-1:0]  prod_r;
  logic               steer_v_r;
  logic [STEER_W-1:0] steer_r;
  logic               speed_v_r;
  logic [SPEED_W-1:0] speed_r;

  // Output register.
  logic               out_valid_r;
  logic               out_steer_v_r;
  logic [STEER_W-1:0] out_steer_r;
  logic               out_speed_v_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic [LAPS_W-1:0]  out_laps_r;

  // Decode of the resolved pattern.
  logic [ONES_W-1:0] ones;
  logic [POS_W-1:0]  pos;
  logic [K_W-1:0]    k;
  logic              single;
  logic              lap_go;
  logic              rec_go;
  logic [CW:0]       idx_p1;
  logic              mark_fits;

  // Shared multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;

  // Corner store port.
  logic                st_wr_en;
  logic [IW-1:0]       st_wr_addr;
  logic [CORNER_W-1:0] st_wr_data;
  logic [IW-1:0]       st_rd_addr;
  logic [CORNER_W-1:0] st_rd_value;

  // Scan and boost arithmetic.
  logic                scan_hit;
  logic [PROD_W-1:0]   m_full;

  logic in_fire;
  logic cfg_wr;
  cfg_reg_t cfg_sel;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is
  // tied high so there are never wait states.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      slow_r   <= '0;
      margin_r <= '0;
      bpr_r    <= '0;
      limit_r  <= UNITY_Q8;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_BASE_SPEED:    base_r   <= pwdata[BASE_W-1:0];
        REG_CORNER_SLOW:   slow_r   <= pwdata[SLOW_W-1:0];
        REG_CORNER_MARGIN: margin_r <= pwdata[MARGIN_W-1:0];
        REG_BOOST_PER_ROT: bpr_r    <= pwdata[BOOST_W-1:0];
        REG_BOOST_LIMIT:   limit_r  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_BASE_SPEED:    prdata = CFG_DATA_W'(base_r);
      REG_CORNER_SLOW:   prdata = CFG_DATA_W'(slow_r);
      REG_CORNER_MARGIN: prdata = CFG_DATA_W'(margin_r);
      REG_BOOST_PER_ROT: prdata = CFG_DATA_W'(bpr_r);
      REG_BOOST_LIMIT:   prdata = CFG_DATA_W'(limit_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pattern decode. The pattern register already holds the previous
  // nonzero pattern in place of an all-zero sample.
  // ---------------------------------------------------------------------
  assign ones   = count_ones(pat_r);
  assign pos    = bit_pos(pat_r);
  assign k      = corner_k(pos);
  assign single = (ones == ONES_W'(1));

  // A lap is counted on a wide pattern, once per lap-flag window. An end
  // marker goes just after the current corner when there is room for it.
  assign lap_go    = (op_r == OP_SENSE) && (ones > ONES_W'(4)) && !lflag_r;
  assign idx_p1    = {1'b0, idx_r} + (CW + 1)'(1);
  assign mark_fits = idx_p1 < (CW + 1)'(CORNER_SLOTS);

  // An outer single bit records the corner distance once per tick.
  assign rec_go = (op_r == OP_SENSE) && single && (k != '0) &&
                  (idx_r < CW'(CORNER_SLOTS)) && !cflag_r;

  always_comb begin
    st_wr_en   = 1'b0;
    st_wr_addr = idx_r[IW-1:0];
    st_wr_data = rot_r;
    if (state_r == S_DECODE) begin
      if (lap_go) begin
        st_wr_en   = mark_fits;
        st_wr_addr = idx_p1[IW-1:0];
        st_wr_data = END_MARK;
      end else begin
        st_wr_en = rec_go;
      end
    end
  end

  // The scan reads one entry ahead of the one being checked, so that one
  // entry is examined in every cycle.
  always_comb begin
    case (state_r)
      S_SCAN:  st_rd_addr = (chk_r == LAST_SLOT) ? '0 : IW'(chk_r + 1'b1);
      default: st_rd_addr = '0;
    endcase
  end

  lfss_corner_store #(
    .SLOTS (CORNER_SLOTS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_data  (st_wr_data),
    .rd_addr  (st_rd_addr),
    .rd_value (st_rd_value)
  );

  // The first stored corner at or beyond the current distance, or the end
  // marker, stops the scan.
  assign scan_hit = (st_rd_value >= rot_r) || (st_rd_value == END_MARK);

  // ---------------------------------------------------------------------
  // Shared multiplier. Its operands are chosen by the sequencer state and
  // the product is registered before anything else uses it.
  //   S_CUT : slowdown multiple times c
  //   S_CSPD: base speed times the Q9 corner factor
  //   S_BMUL: rotations beyond the margin times the boost step
  //   S_SPD : base speed times the Q8 boost multiplier
  // ---------------------------------------------------------------------
  always_comb begin
    case (state_r)
      S_CUT: begin
        mul_a = MUL_A_W'(k);
        mul_b = MUL_B_W'(slow_r);
      end
      S_CSPD: begin
        mul_a = MUL_A_W'(base_r);
        mul_b = ONE_Q9 - prod_r[MUL_B_W-1:0];
      end
      S_BMUL: begin
        mul_a = excess_r;
        mul_b = MUL_B_W'(bpr_r);
      end
      S_SPD: begin
        mul_a = MUL_A_W'(base_r);
        mul_b = m_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= mul_prod;
  end

  assign m_full = prod_r + PROD_W'(UNITY_Q8);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      idx_r       <= '0;
      cflag_r     <= 1'b0;
      lflag_r     <= 1'b0;
      laps_r      <= '0;
      rot_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded instead of emptied.
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= op_t'(in_ch.op);
            pat_r   <= (in_ch.line_pattern == '0) ? prev_r : in_ch.line_pattern;
            tach_r  <= in_ch.tach_pulses;
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          speed_r <= '0;
          if (op_r == OP_TICK) begin
            // A tick reopens corner recording; the lap window closes on
            // every eighth tick.
            steer_v_r <= 1'b0;
            steer_r   <= '0;
            speed_v_r <= 1'b0;
            cflag_r   <= 1'b0;
            if (phase_r == '0) begin
              lflag_r <= 1'b0;
            end
            phase_r <= phase_r + 3'd1;
            rot_r   <= rot_r + ROT_W'(tach_r);
            state_r <= S_DONE;
          end else begin
            if (lap_go) begin
              lflag_r <= 1'b1;
              laps_r  <= laps_r + LAPS_W'(1);
              rot_r   <= '0;
              idx_r   <= '0;
            end
            if (rec_go) begin
              cflag_r <= 1'b1;
              idx_r   <= idx_r + CW'(1);
            end
            if (pat_r != '0) begin
              prev_r <= pat_r;
            end
            steer_v_r <= (ones != '0);
            speed_v_r <= single;
            if (single) begin
              steer_r <= servo_cmp(pos);
            end else if (ones != '0) begin
              steer_r <= STEER_CENTRE;
            end else begin
              steer_r <= '0;
            end
            if (single && (k != '0)) begin
              state_r <= S_CUT;
            end else if (single && (laps_r > LAPS_W'(1))) begin
              state_r <= S_SCAN_RD;
            end else if (single) begin
              m_r     <= UNITY_Q8;
              state_r <= S_SPD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end

        S_CUT: begin
          state_r <= S_CSPD;
        end

        S_CSPD: begin
          // A cut of one or more leaves no speed at all.
          if (prod_r[PROD_W-1:9] != '0) begin
            speed_r <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_CSAT;
          end
        end

        S_CSAT: begin
          speed_r <= sat_speed(prod_r[PROD_W-1:9]);
          state_r <= S_DONE;
        end

        S_SCAN_RD: begin
          chk_r   <= '0;
          state_r <= S_SCAN;
        end

        S_SCAN: begin
          if (scan_hit) begin
            excess_r <= st_rd_value - rot_r;
            state_r  <= S_MARG;
          end else if (chk_r == LAST_SLOT) begin
            m_r     <= UNITY_Q8;
            state_r <= S_SPD;
          end else begin
            chk_r <= chk_r + IW'(1);
          end
        end

        S_MARG: begin
          if (excess_r > margin_r) begin
            excess_r <= excess_r - margin_r;
            state_r  <= S_BMUL;
          end else begin
            m_r     <= UNITY_Q8;
            state_r <= S_SPD;
          end
        end

        S_BMUL: begin
          state_r <= S_BCAP;
        end

        S_BCAP: begin
          // The cap is applied only once a boost has been added.
          if (m_full > PROD_W'(limit_r)) begin
            m_r <= limit_r;
          end else begin
            m_r <= m_full[LIMIT_W-1:0];
          end
          state_r <= S_SPD;
        end

        S_SPD: begin
          state_r <= S_SSAT;
        end

        S_SSAT: begin
          speed_r <= sat_speed(prod_r[SAT_IN_W+7:8]);
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_steer_v_r <= steer_v_r;
            out_steer_r   <= steer_r;
            out_speed_v_r <= speed_v_r;
            out_speed_r   <= speed_r;
            out_laps_r    <= laps_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.steer_valid      = out_steer_v_r;
  assign out_ch.steering_compare = out_steer_r;
  assign out_ch.speed_valid      = out_speed_v_r;
  assign out_ch.speed_command    = out_speed_r;
  assign out_ch.lap_count        = out_laps_r;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  `LFSS_ASSERT(a_accept_decode, clk, rst_n, in_fire |=> (state_r == S_DECODE))
  `LFSS_ASSERT_NEVER(a_index_range, clk, rst_n, idx_r > CW'(CORNER_SLOTS))
  `LFSS_ASSERT(a_speed_sat, clk, rst_n, out_valid_r |-> (out_speed_r <= SPEED_MAX))
  `LFSS_ASSERT(a_speed_steer, clk, rst_n, (out_valid_r && out_speed_v_r) |-> out_steer_v_r)
  `LFSS_ASSERT(a_lap_flag, clk, rst_n, (laps_r != $past(laps_r)) |-> lflag_r)

endmodule

`default_nettype wire

// ===== bench/steer_speed_checker.sv =====
// ----------------------------------------------------------------------------
// Steering and speed checker
// Watches the sensor, result and register ports of the line-follower block,
// keeps its own copy of the car state, predicts each result item and compares
// it field by field with what the block sends.
// ----------------------------------------------------------------------------
module steer_speed_checker #(
  parameter int CORNER_SLOTS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lfss_in_if                                   in_ch,
  lfss_out_if                                  out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic                            pready,
  input  wire logic [lfss_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lfss_pkg::CFG_DATA_W-1:0] pwdata,
  output int                                   cmds_due,
  output int                                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import lfss_pkg::*;

  typedef struct packed {
    logic               steer_valid;
    logic [STEER_W-1:0] steer;
    logic               speed_valid;
    logic [SPEED_W-1:0] speed;
    logic [LAPS_W-1:0]  laps;
  } drive_cmd_t;

  // Servo offset (angle plus 45 degrees) and slowdown multiple for each bit.
  localparam int unsigned ANGLE_OFS [8] = '{0, 15, 30, 40, 50, 60, 75, 90};
  localparam int unsigned SLOW_MULT [8] = '{10, 9, 8, 0, 0, 8, 9, 10};

  drive_cmd_t          due_q[$];
  int                  bad;

  logic [BASE_W-1:0]   base_speed;
  logic [SLOW_W-1:0]   slowdown;
  logic [MARGIN_W-1:0] margin;
  logic [BOOST_W-1:0]  boost_rate;
  logic [LIMIT_W-1:0]  boost_cap;

  logic [PAT_W-1:0]    last_pattern;
  logic [CORNER_W-1:0] corner_rot [CORNER_SLOTS];
  int unsigned         corner_next;
  logic                corner_seen;
  logic                lap_seen;
  logic [LAPS_W-1:0]   lap_total;
  logic [ROT_W-1:0]    rot_count;
  logic [2:0]          tick_count;

  function automatic int unsigned servo_value(input int unsigned offset);
    return (offset * 700 / 90 + 1150) / 4;
  endfunction

  function automatic int unsigned cap_speed(input int unsigned v);
    return (v > 100) ? 100 : v;
  endfunction

  function automatic int unsigned corner_speed(input int unsigned mult);
    int unsigned cut;
    cut = mult * slowdown;
    if (cut >= 512) return 0;
    return cap_speed((base_speed * (512 - cut)) >> 9);
  endfunction

  // Q8 speed multiplier learned from the distance to the next stored corner.
  function automatic int unsigned boost_q8();
    int unsigned slot;
    int unsigned ahead;
    int unsigned m;
    slot = 0;
    m = 256;
    if (lap_total <= 1) return m;
    while (slot < CORNER_SLOTS && corner_rot[slot] < rot_count &&
           corner_rot[slot] != END_MARK) slot++;
    if (slot >= CORNER_SLOTS) return m;
    ahead = corner_rot[slot] - rot_count;
    if (ahead > margin) begin
      m = 256 + (ahead - margin) * boost_rate;
      if (m > boost_cap) m = boost_cap;
    end
    return m;
  endfunction

  function automatic drive_cmd_t drive_for_item(input logic op, input logic [PAT_W-1:0] pattern,
                                                input logic [TACH_W-1:0] pulses);
    drive_cmd_t  c;
    logic [PAT_W-1:0] pat;
    int unsigned ones;
    int unsigned pos;
    c = '0;
    if (op == OP_TICK) begin
      corner_seen = 1'b0;
      if (tick_count == 3'd0) lap_seen = 1'b0;
      tick_count = tick_count + 3'd1;
      rot_count = rot_count + ROT_W'(pulses);
    end else begin
      pat = (pattern == '0) ? last_pattern : pattern;
      ones = $countones(pat);
      if (ones > 4 && !lap_seen) begin
        if (corner_next + 1 < CORNER_SLOTS) corner_rot[corner_next + 1] = END_MARK;
        lap_seen = 1'b1;
        lap_total = lap_total + 8'd1;
        rot_count = '0;
        corner_next = 0;
      end
      if (ones > 1) begin
        c.steer_valid = 1'b1;
        c.steer = STEER_W'(servo_value(45));
      end
      if (ones == 1) begin
        pos = 0;
        for (int b = 0; b < PAT_W; b++) begin
          if (pat[b]) pos = b;
        end
        c.steer_valid = 1'b1;
        c.speed_valid = 1'b1;
        c.steer = STEER_W'(servo_value(ANGLE_OFS[pos]));
        if (SLOW_MULT[pos] == 0) begin
          c.speed = SPEED_W'(cap_speed((base_speed * boost_q8()) >> 8));
        end else begin
          c.speed = SPEED_W'(corner_speed(SLOW_MULT[pos]));
          if (corner_next < CORNER_SLOTS && !corner_seen) begin
            corner_rot[corner_next] = rot_count;
            corner_seen = 1'b1;
            corner_next++;
          end
        end
      end
      if (pat != '0) last_pattern = pat;
    end
    c.laps = lap_total;
    return c;
  endfunction

  always @(posedge clk) begin : watch
    drive_cmd_t want;
    drive_cmd_t got;
    if (!rst_n) begin
      base_speed   = '0;
      slowdown     = '0;
      margin       = '0;
      boost_rate   = '0;
      boost_cap    = UNITY_Q8;
      last_pattern = '0;
      for (int i = 0; i < CORNER_SLOTS; i++) corner_rot[i] = '0;
      corner_next  = 0;
      corner_seen  = 1'b0;
      lap_seen     = 1'b0;
      lap_total    = '0;
      rot_count    = '0;
      tick_count   = '0;
      bad          = 0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[CFG_ADDR_W-1:2]))
          REG_BASE_SPEED:    base_speed = pwdata[BASE_W-1:0];
          REG_CORNER_SLOW:   slowdown   = pwdata[SLOW_W-1:0];
          REG_CORNER_MARGIN: margin     = pwdata[MARGIN_W-1:0];
          REG_BOOST_PER_ROT: boost_rate = pwdata[BOOST_W-1:0];
          REG_BOOST_LIMIT:   boost_cap  = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        due_q.push_back(drive_for_item(in_ch.op, in_ch.line_pattern, in_ch.tach_pulses));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.steer_valid, out_ch.steering_compare, out_ch.speed_valid,
                out_ch.speed_command, out_ch.lap_count};
        if (due_q.size() == 0) begin
          if (bad < 10) $display("result item arrived with none outstanding: steer %0b/%0d speed %0b/%0d laps %0d",
                                 got.steer_valid, got.steer, got.speed_valid, got.speed, got.laps);
          bad++;
        end else begin
          want = due_q.pop_front();
          if (want !== got) begin
            if (bad < 10) begin
              $display("mismatch: expected steer %0b/%0d speed %0b/%0d laps %0d",
                       want.steer_valid, want.steer, want.speed_valid, want.speed, want.laps);
              $display("          got      steer %0b/%0d speed %0b/%0d laps %0d",
                       got.steer_valid, got.steer, got.speed_valid, got.speed, got.laps);
            end
            bad++;
          end
        end
      end
    end
    cmds_due   <= due_q.size();
    mismatches <= bad;
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Line-follower steering and speed testbench
// Drives sensor and tick items into the block with random idling on both
// channels, programs the registers between phases, and leaves prediction and
// comparison to the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfss_pkg::*;

  localparam int CORNER_SLOTS = 16;
  localparam int PHASE_ITEMS  = 130;
  // The slowest item meets the longest idle gap from the sender, a full corner
  // scan in the block and the longest stall at the receiver, so nothing moving
  // for the whole limit means the block has hung.
  localparam int STALL_LIMIT  = 2000;
  localparam logic [PAT_W-1:0] OUTER_BITS [6] = '{8'h01, 8'h02, 8'h04, 8'h20, 8'h40, 8'h80};

  // The opening sequence: a zero pattern with nothing remembered, every single
  // bit, a two-bit pattern, two laps with a corner between them so that the
  // boost path is reached, the remembered pattern and the extreme tick counts.
  localparam logic [8:0] OPENING [24] = '{
    {OP_SENSE, 8'h00}, {OP_SENSE, 8'h01}, {OP_SENSE, 8'h02}, {OP_SENSE, 8'h04},
    {OP_SENSE, 8'h08}, {OP_SENSE, 8'h10}, {OP_SENSE, 8'h20}, {OP_SENSE, 8'h40},
    {OP_SENSE, 8'h80}, {OP_SENSE, 8'h03}, {OP_SENSE, 8'hff}, {OP_TICK,  8'hff},
    {OP_SENSE, 8'h01}, {OP_SENSE, 8'h1f}, {OP_TICK,  8'h00}, {OP_SENSE, 8'h08},
    {OP_SENSE, 8'h10}, {OP_TICK,  8'hc8}, {OP_SENSE, 8'h10}, {OP_SENSE, 8'h00},
    {OP_SENSE, 8'h80}, {OP_SENSE, 8'h0f}, {OP_TICK,  8'h00}, {OP_SENSE, 8'h40}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lfss_in_if  in_ch();
  lfss_out_if out_ch();

  int cmds_due;
  int mismatches;
  int phase_items;
  int idle_cycles;
  int out_hold;
  int stall_draw;
  bit in_quiet;
  bit out_quiet;

  line_follower_steer_speed_core #(.CORNER_SLOTS(CORNER_SLOTS)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  steer_speed_checker #(.CORNER_SLOTS(CORNER_SLOTS)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .cmds_due   (cmds_due),
    .mismatches (mismatches)
  );

  always #1 clk = ~clk;

  // The result side draws a stall after every accepted item, so that ready
  // also drops while the block is still working on the next one. Now and then
  // it switches into a quiet stretch in which it never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_draw = out_quiet ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 19) == 0) out_quiet = !out_quiet;
      out_hold <= stall_draw;
      out_ch.ready <= (stall_draw == 0);
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_ch.ready <= (out_hold == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: any accepted item or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item after a random gap and returns at the edge where it is
  // taken. Valid is only lowered when a gap follows, so that back-to-back
  // items never see valid dropped and raised in the same time step. The field
  // that the operation does not use carries random bits.
  task automatic send_item(input op_t op, input logic [7:0] value);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 19) == 0) in_quiet = !in_quiet;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.line_pattern <= PAT_W'($urandom);
      in_ch.tach_pulses <= TACH_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.line_pattern <= (op == OP_SENSE) ? value : PAT_W'($urandom);
    in_ch.tach_pulses <= (op == OP_TICK) ? value : TACH_W'($urandom);
    do @(posedge clk); while (!in_ch.ready);
    phase_items++;
  endtask

  // One register write: a setup phase, then access until pready. The upper
  // bits of the write data are random, as the register keeps its own width.
  task automatic write_reg(input cfg_reg_t r, input int unsigned value, input int w);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= ($urandom << w) | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input int unsigned base, input int unsigned slow,
                           input int unsigned margin, input int unsigned rate,
                           input int unsigned limit);
    write_reg(REG_BASE_SPEED, base, BASE_W);
    write_reg(REG_CORNER_SLOW, slow, SLOW_W);
    write_reg(REG_CORNER_MARGIN, margin, MARGIN_W);
    write_reg(REG_BOOST_PER_ROT, rate, BOOST_W);
    write_reg(REG_BOOST_LIMIT, limit, LIMIT_W);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stops offering items and waits until every predicted result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cmds_due != 0);
  endtask

  initial begin
    int steps;
    int sel;
    logic [PAT_W-1:0] pat;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SENSE;
    in_ch.line_pattern = '0;
    in_ch.tach_pulses = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. The base speed is kept below saturation so that the
    // boost multiplier shows up in the speed.
    configure(60, 51, 10, 3, 600);
    foreach (OPENING[i]) send_item(op_t'(OPENING[i][8]), OPENING[i][7:0]);
    drain_results();

    // Random phases. The first three use the register extremes: full speed
    // with the strongest slowdown and boost, everything off with the largest
    // margin, and out-of-range values including a cap below one.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(100, 51, 0, 255, 1023);
        1: configure(0, 0, 65535, 0, 256);
        2: configure(127, 63, 0, 1, 0);
        default: configure($urandom_range(0, 127), $urandom_range(0, 63),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 300),
                           $urandom_range(0, 255), $urandom_range(0, 1023));
      endcase
      phase_items = 0;

      // One long drive without laps: the rotation count wraps, the corner
      // store fills up and the scan can run off its end.
      if (ph == 4) begin
        repeat (300) begin
          send_item(OP_TICK, 8'hff);
          if ($urandom_range(0, 3) == 0) send_item(OP_SENSE, 8'h01 << $urandom_range(0, 7));
        end
      end

      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          // A lap: the finish line, then a drive of ticks, corners and
          // straights, with the odd remembered or multi-bit pattern.
          do pat = PAT_W'($urandom); while ($countones(pat) < 5);
          send_item(OP_SENSE, pat);
          steps = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90) : $urandom_range(10, 40);
          repeat (steps) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
              send_item(OP_TICK, $urandom_range(0, 1) ? TACH_W'($urandom_range(0, 31))
                                                      : TACH_W'($urandom));
            end else if (sel < 60) begin
              send_item(OP_SENSE, OUTER_BITS[$urandom_range(0, 5)]);
            end else if (sel < 85) begin
              send_item(OP_SENSE, $urandom_range(0, 1) ? 8'h08 : 8'h10);
            end else if (sel < 90) begin
              send_item(OP_SENSE, 8'h00);
            end else if (sel < 95) begin
              do pat = PAT_W'($urandom); while ($countones(pat) < 2 || $countones(pat) > 4);
              send_item(OP_SENSE, pat);
            end else begin
              send_item(OP_SENSE, PAT_W'($urandom));
            end
          end
        end else begin
          // Noise: fully random items of either kind.
          repeat ($urandom_range(5, 20)) send_item(op_t'($urandom_range(0, 1)), 8'($urandom));
        end
      end
      drain_results();
    end

    // Let a late or spurious result item show itself before the verdict.
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
